// File: design/deq_pkg.sv
// Shared constants, request/status codes and the cell control bundle of the deque.
package deq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } deq_req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    // broadcast to every cell for one accepted beat
    typedef struct packed {
        logic                 push_front;
        logic                 push_back;
        logic                 pop_front;
        logic [CNT_W-1:0]     count;
        logic [WORD_BITS-1:0] word;
    } deq_ctl_t;

endpackage

// File: design/deq_cell.sv
// One storage cell of the deque shift chain.
module deq_cell (
    input  logic                          aclk,
    input  deq_pkg::deq_ctl_t             ctl,
    input  logic [deq_pkg::IDX_W-1:0]     my_idx,
    input  logic [deq_pkg::WORD_BITS-1:0] left_in,
    input  logic [deq_pkg::WORD_BITS-1:0] right_in,
    output logic [deq_pkg::WORD_BITS-1:0] data_out,
    output logic [deq_pkg::WORD_BITS-1:0] back_rd
);
    import deq_pkg::*;

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic [CNT_W-1:0]     idx_ext;

    assign idx_ext = CNT_W'(my_idx);

    always_comb begin
        data_next = data_reg;
        if (ctl.push_front) begin
            data_next = left_in;
        end else if (ctl.pop_front) begin
            data_next = right_in;
        end else if (ctl.push_back && (ctl.count == idx_ext)) begin
            data_next = ctl.word;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    // this cell holds the back element when count == idx + 1
    assign back_rd  = (ctl.count == idx_ext + CNT_W'(1)) ? data_reg : '0;

endmodule

// File: design/double_ended_queue.sv
// Top level of the deque: a chain of shift cells with a registered result stage.
// An accepted request's result is registered and presented in the cycle after acceptance.
// One request per cycle unless an unread result holds s_ready low.
// Pushes at the front shift the chain toward the back, pops at the front shift it forward.
// Reset clears the element count and the result valid flag; cell words are not reset.
module double_ended_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [deq_pkg::WORD_BITS-1:0] s_push_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [deq_pkg::WORD_BITS-1:0] m_popped_value,
    output logic [1:0]                    m_status,
    output logic [deq_pkg::CNT_W-1:0]     m_element_count
);
    import deq_pkg::*;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [WORD_BITS-1:0] popped_reg;
    logic [WORD_BITS-1:0] popped_next;
    deq_status_t          status_reg;
    deq_status_t          status_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [WORD_BITS-1:0] back_word;
    deq_ctl_t             ctl;

    logic [WORD_BITS-1:0] cell_data [DEPTH];
    logic [WORD_BITS-1:0] cell_rd   [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    always_comb begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_word = back_word | cell_rd[i];
        end
    end

    always_comb begin
        ctl.push_front = 1'b0;
        ctl.push_back  = 1'b0;
        ctl.pop_front  = 1'b0;
        ctl.count      = count_reg;
        ctl.word       = s_push_value;
        count_next     = count_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        if (accept) begin
            popped_next = '0;
            status_next = ST_OK;
            case (deq_req_t'(s_req_type))
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        ctl.push_front = (deq_req_t'(s_req_type) == REQ_PUSH_FRONT);
                        ctl.push_back  = (deq_req_t'(s_req_type) == REQ_PUSH_BACK);
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        ctl.pop_front = 1'b1;
                        popped_next   = cell_data[0];
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                REQ_POP_BACK: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        popped_next = back_word;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [WORD_BITS-1:0] left_w;
            logic [WORD_BITS-1:0] right_w;
            if (g == 0) begin : g_head
                assign left_w = s_push_value;
            end else begin : g_mid
                assign left_w = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_w = '0;
            end else begin : g_next
                assign right_w = cell_data[g+1];
            end
            deq_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .my_idx   (IDX_W'(g)),
                .left_in  (left_w),
                .right_in (right_w),
                .data_out (cell_data[g]),
                .back_rd  (cell_rd[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_popped_value  = popped_reg;
    assign m_status        = status_reg;
    assign m_element_count = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_req_type[1] && !full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not grow the count");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> m_element_count == CNT_W'(DEPTH))
        else $error("full status with count below depth");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> (m_element_count == '0) && (m_popped_value == '0))
        else $error("empty status with nonzero count or word");

endmodule

// File: sim/tb.sv
// Self-checking testbench for double_ended_queue: ring-buffer shadow model, random handshakes.
`timescale 1ns / 100ps

module tb;
    import deq_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASES      = 18;
    localparam int PHASE_ITEMS = 90;

    typedef struct {
        logic [WORD_BITS-1:0] popped;
        deq_status_t          status;
        logic [CNT_W-1:0]     count;
    } deq_result_t;

    // Mirrors the deque contents and queues the result each request must produce.
    class deque_shadow;
        logic [WORD_BITS-1:0] slots [DEPTH];
        logic [IDX_W-1:0]     head;
        logic [CNT_W-1:0]     occupancy;
        deq_result_t          awaited [$];
        int                   errors;

        function new();
            head      = '0;
            occupancy = '0;
            errors    = 0;
        endfunction

        function void note_request(deq_req_t req, logic [WORD_BITS-1:0] word);
            deq_result_t      r;
            logic [IDX_W-1:0] slot;
            r.popped = '0;
            r.status = ST_OK;
            case (req)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (occupancy == CNT_W'(DEPTH)) begin
                        r.status = ST_FULL;
                    end else if (req == REQ_PUSH_FRONT) begin
                        head        = head - 1'b1;
                        slots[head] = word;
                        occupancy   = occupancy + 1'b1;
                    end else begin
                        slot        = head + IDX_W'(occupancy);
                        slots[slot] = word;
                        occupancy   = occupancy + 1'b1;
                    end
                end
                default: begin
                    if (occupancy == '0) begin
                        r.status = ST_EMPTY;
                    end else if (req == REQ_POP_FRONT) begin
                        r.popped  = slots[head];
                        head      = head + 1'b1;
                        occupancy = occupancy - 1'b1;
                    end else begin
                        slot      = head + IDX_W'(occupancy) - 1'b1;
                        r.popped  = slots[slot];
                        occupancy = occupancy - 1'b1;
                    end
                end
            endcase
            r.count = occupancy;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [WORD_BITS-1:0] popped, logic [1:0] status,
                                   logic [CNT_W-1:0] count);
            deq_result_t r;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected beat: value %h status %0d count %0d",
                         $time, popped, status, count);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (popped !== r.popped) begin
                $display("%0t: popped_value expected %h actual %h", $time, r.popped, popped);
                errors++;
            end
            if (status !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, status);
                errors++;
            end
            if (count !== r.count) begin
                $display("%0t: element_count expected %0d actual %0d", $time, r.count, count);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_req_type      = REQ_PUSH_FRONT;
    logic [WORD_BITS-1:0] s_push_value    = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [WORD_BITS-1:0] m_popped_value;
    logic [1:0]           m_status;
    logic [CNT_W-1:0]     m_element_count;

    deque_shadow shadow;
    bit          no_idle      = 1'b0;
    bit          hold_off_req = 1'b0;
    int          cycles       = 0;

    double_ended_queue i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_push_value    (s_push_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_popped_value  (m_popped_value),
        .m_status        (m_status),
        .m_element_count (m_element_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_request(input deq_req_t req, input logic [WORD_BITS-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_push_value <= word;
        do @(posedge aclk); while (!s_ready);
        shadow.note_request(req, word);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_word();
        int bit_pos;
        bit_pos = $urandom_range(0, WORD_BITS - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return WORD_BITS'(1) << bit_pos;
            3:       return ~(WORD_BITS'(1) << bit_pos);
            default: return $urandom;
        endcase
    endfunction

    function automatic deq_req_t pick_request(int push_pct);
        bit at_back;
        at_back = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < push_pct)
            return at_back ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        return at_back ? REQ_POP_BACK : REQ_POP_FRONT;
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_req) begin
                stall        = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            shadow.check_result(m_popped_value, m_status, m_element_count);
        end
    end

    initial begin
        int push_pct [6] = '{80, 20, 50, 95, 5, 50};
        shadow = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pops, single-element queue from both ends
        send_request(REQ_POP_FRONT, '1);
        send_request(REQ_POP_BACK, 32'hA5A5_5A5A);
        send_request(REQ_PUSH_FRONT, '0);
        send_request(REQ_POP_BACK, '1);
        send_request(REQ_PUSH_BACK, '1);
        send_request(REQ_POP_FRONT, '0);
        // fill from both ends, then refused pushes at each end and a pop at each end
        for (int i = 0; i < DEPTH; i++) begin
            send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                         i[0] ? ~(WORD_BITS'(1) << i) : (WORD_BITS'(1) << (WORD_BITS - 1 - i)));
        end
        send_request(REQ_PUSH_FRONT, 32'h3F80_0000);
        send_request(REQ_PUSH_BACK, 32'hFF80_0000);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            no_idle = (phase % 4 == 1);
            if (phase == 5)
                hold_off_req = 1'b1;
            if (phase % 6 == 3)
                wait_drained();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_request(push_pct[phase % 6]), pick_word());
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (4) @(posedge aclk);
        if (shadow.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
